[src/amti_pkg.sv]
// Package for the accelerometer magnitude interpolator.
// Holds the item types, operation codes, fixed widths and the back-end state type.
// No dependencies.
package amti_pkg;

    localparam int ACC_W  = 16;
    localparam int TIME_W = 32;
    localparam int MAG_W  = 24;
    localparam int SQ_W   = 32;
    localparam int RAD_W  = 48;
    localparam int DIV_W  = 32;
    localparam int CNT_W  = 6;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_SLOT  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [15:0]       REST_RESET  = 16'd1000;
    localparam logic [16:0]       WEIGHT_ONE  = 17'h10000;
    localparam logic [5:0]        WEIGHT_BITS = 6'd16;
    localparam logic [5:0]        NORM_BITS   = 6'd32;
    localparam logic signed [23:0] NORM_MAX   = 24'sh7FFFFF;
    localparam logic signed [23:0] NORM_MIN   = 24'sh800000;
    localparam logic [31:0]       NORM_POS_LIM = 32'd8388607;
    localparam logic [31:0]       NORM_NEG_LIM = 32'd8388608;

    typedef struct packed {
        logic [1:0]         op;
        logic               received;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        sample_time;
        logic [31:0]        query_time;
    } t_in_item;

    typedef struct packed {
        logic [23:0]        magnitude;
        logic signed [23:0] normalized;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_accel;

    typedef struct packed {
        t_accel      acc;
        logic [31:0] t;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BEGIN,
        S_SLOT,
        S_SLOT_APPEND,
        S_WALK,
        S_WALK_CHK,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_SQ,
        S_ROOT_GO,
        S_ROOT,
        S_WEIGHT,
        S_DIVW,
        S_MUL,
        S_INTERP,
        S_NORM,
        S_NORMW
    } t_back_state;

endpackage

[src/amti_front.sv]
// Front end of the interpolator: takes command beats, drops the no-op code,
// and holds up to two items for the back end. Depends on amti_pkg.
module amti_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  amti_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output amti_pkg::t_in_item  o_item,
    input  logic                i_ready
);
    import amti_pkg::*;

    t_in_item   r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    assign busy    = (r_fill == 2'd2);
    assign push    = start && !busy && (i_item.op != OP_NONE);
    assign o_valid = (r_fill != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_slot[r_rd];

    // store accepted beats
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

[src/amti_isqrt.sv]
// Bit-pair integer square root, one root bit per cycle.
// Depends on amti_pkg.
module amti_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [47:0] i_radicand,
    output logic        o_done,
    output logic [23:0] o_root
);
    import amti_pkg::*;

    logic [RAD_W-1:0] r_val;
    logic [25:0]      r_rem;
    logic [23:0]      r_root;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [27:0]      trial_rem;
    logic [27:0]      trial;
    logic             ge;

    assign trial_rem = {r_rem, r_val[RAD_W-1 -: 2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign ge        = (trial_rem >= trial);
    assign o_done    = r_done;
    assign o_root    = r_root;

    // run one digit step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_val  <= i_radicand;
            r_rem  <= 26'd0;
            r_root <= 24'd0;
        end else if (r_busy) begin
            r_val  <= {r_val[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? 26'(trial_rem - trial) : trial_rem[25:0];
            r_root <= {r_root[22:0], ge};
        end
    end

endmodule

[src/amti_div.sv]
// Restoring divider, one quotient bit per cycle, shared by weight and
// normalization. Depends on amti_pkg.
module amti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_rem,
    input  logic [31:0] i_dvd,
    input  logic [31:0] i_dvs,
    input  logic [5:0]  i_steps,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import amti_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   trial;
    logic             ge;

    assign trial  = {r_rem, r_dvd[DIV_W-1]};
    assign ge     = (trial >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_quot;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift, compare, subtract
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem  <= i_rem;
            r_dvd  <= i_dvd;
            r_dvs  <= i_dvs;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? DIV_W'(trial - {1'b0, r_dvs}) : trial[DIV_W-1:0];
            r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], ge};
        end
    end

endmodule

[src/amti_back.sv]
// Back end of the interpolator: point table, walk pointer, magnitudes,
// weight, interpolation and normalization. Depends on amti_pkg, amti_isqrt, amti_div.
module amti_back #(
    parameter int MAX_POINTS = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  amti_pkg::t_in_item  i_item,
    output logic                o_ready,
    input  logic [15:0]         i_rest,
    output logic                o_valid,
    output amti_pkg::t_out_item o_result
);
    import amti_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_entry        r_mem [MAX_POINTS];
    t_entry        r_rd;
    t_back_state   r_state;
    t_back_state   n_state;
    t_in_item      r_item;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_wp;
    t_entry        r_end;
    logic          r_first;
    logic          r_open;
    t_entry        r_e0;
    t_entry        r_e1;
    logic [1:0]    r_sq_cnt;
    logic [SQ_W-1:0] r_acc;
    logic          r_sel;
    logic [MAG_W-1:0] r_m1;
    logic [MAG_W-1:0] r_m2;
    logic [16:0]   r_w;
    logic [40:0]   r_prod;
    logic [MAG_W-1:0] r_mag;
    logic          r_neg;
    logic          r_valid;
    t_out_item     r_result;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [AW-1:0] rd_addr;
    logic          sqrt_go;
    logic          sqrt_done;
    logic [23:0]   sqrt_root;
    logic          div_go;
    logic [31:0]   div_rem;
    logic [31:0]   div_dvd;
    logic [31:0]   div_dvs;
    logic [5:0]    div_steps;
    logic          div_done;
    logic [31:0]   div_quot;

    t_entry        slot;
    logic          room;
    logic          walk_more;
    logic [31:0]   span;
    logic [31:0]   elapsed;
    t_accel        cur;
    logic signed [15:0] comp;
    logic signed [31:0] sq;
    logic [MAG_W-1:0] diff;
    logic signed [25:0] dnorm;
    logic [25:0]   dabs;
    logic [15:0]   rest_eff;
    logic [AW-1:0] wp_next;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign slot.acc.x = r_item.accel_x;
    assign slot.acc.y = r_item.accel_y;
    assign slot.acc.z = r_item.accel_z;
    assign slot.t     = r_item.sample_time;
    assign room       = (r_count < CW'(MAX_POINTS));
    assign walk_more  = ((CW'(r_wp) + CW'(2)) < r_count);
    assign wp_next    = r_wp + AW'(1);
    assign span       = r_e1.t - r_e0.t;
    assign elapsed    = r_item.query_time - r_e0.t;
    assign cur        = r_sel ? r_e1.acc : r_e0.acc;
    assign sq         = comp * comp;
    assign diff       = (r_m2 >= r_m1) ? (r_m2 - r_m1) : (r_m1 - r_m2);
    assign rest_eff   = (i_rest == 16'd0) ? 16'd1 : i_rest;
    assign dnorm      = $signed({2'b00, r_mag}) - $signed({2'b00, rest_eff, 8'h00});
    assign dabs       = dnorm[25] ? 26'(-dnorm) : dnorm;

    // pick the axis being squared
    always_comb begin
        unique case (r_sq_cnt)
            2'd0:    comp = cur.x;
            2'd1:    comp = cur.y;
            default: comp = cur.z;
        endcase
    end

    // point table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    priority case (i_item.op)
                        OP_BEGIN: n_state = S_BEGIN;
                        OP_SLOT:  n_state = S_SLOT;
                        OP_QUERY: n_state = S_WALK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_BEGIN:       n_state = S_IDLE;
            S_SLOT:        n_state = (r_open && r_first) ? S_SLOT_APPEND : S_IDLE;
            S_SLOT_APPEND: n_state = S_IDLE;
            S_WALK: begin
                if (r_count == CW'(0)) begin
                    n_state = S_NORM;
                end else if (walk_more) begin
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_RD_A;
                end
            end
            S_WALK_CHK: n_state = (r_rd.t < r_item.query_time) ? S_WALK : S_RD_A;
            S_RD_A:     n_state = S_RD_B;
            S_RD_B:     n_state = S_RD_C;
            S_RD_C:     n_state = S_SQ;
            S_SQ:       n_state = (r_sq_cnt == 2'd2) ? S_ROOT_GO : S_SQ;
            S_ROOT_GO:  n_state = S_ROOT;
            S_ROOT: begin
                if (sqrt_done) begin
                    if (r_sel) begin
                        n_state = S_WEIGHT;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_NORM;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_WEIGHT: begin
                if (span != 32'd0 && !elapsed[31] && elapsed < span) begin
                    n_state = S_DIVW;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIVW:   n_state = div_done ? S_MUL : S_DIVW;
            S_MUL:    n_state = S_INTERP;
            S_INTERP: n_state = S_NORM;
            S_NORM:   n_state = S_NORMW;
            S_NORMW:  n_state = div_done ? S_IDLE : S_NORMW;
            default:  n_state = S_IDLE;
        endcase
    end

    // table port and unit start controls
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = slot;
        rd_addr   = wp_next;
        sqrt_go   = 1'b0;
        div_go    = 1'b0;
        div_rem   = elapsed;
        div_dvd   = 32'd0;
        div_dvs   = span;
        div_steps = WEIGHT_BITS;
        unique case (r_state)
            S_BEGIN: begin
                mem_we = 1'b1;
                mem_wd = r_end;
            end
            S_SLOT: begin
                if (r_open) begin
                    if (r_first) begin
                        mem_we = 1'b1;
                    end else if (room) begin
                        mem_we = 1'b1;
                        mem_wa = r_count[AW-1:0];
                    end
                end
            end
            S_SLOT_APPEND: begin
                mem_we = room;
                mem_wa = r_count[AW-1:0];
            end
            S_RD_A:    rd_addr = r_wp;
            S_ROOT_GO: sqrt_go = 1'b1;
            S_WEIGHT: begin
                div_go = (span != 32'd0) && !elapsed[31] && (elapsed < span);
            end
            S_NORM: begin
                div_go    = 1'b1;
                div_rem   = 32'd0;
                div_dvd   = {dabs[23:0], 8'h00};
                div_dvs   = {16'd0, rest_eff};
                div_steps = NORM_BITS;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_wp         <= '0;
            r_first      <= 1'b1;
            r_open       <= 1'b0;
            r_valid      <= 1'b0;
            r_end.acc.x  <= 16'sd0;
            r_end.acc.y  <= 16'sd0;
            r_end.acc.z  <= $signed(REST_RESET);
            r_end.t      <= 32'd0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_NORMW) && div_done;
            unique case (r_state)
                S_BEGIN: begin
                    r_wp    <= '0;
                    r_count <= CW'(1);
                    r_open  <= r_item.received;
                end
                S_SLOT: begin
                    if (r_open) begin
                        r_end   <= slot;
                        r_first <= 1'b0;
                        if (!r_first && room) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_SLOT_APPEND: begin
                    if (room) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_WALK_CHK: begin
                    if (r_rd.t < r_item.query_time) begin
                        r_wp <= wp_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_item;
        end
        unique case (r_state)
            S_WALK: begin
                r_mag <= '0;
            end
            S_RD_B: r_e0 <= r_rd;
            S_RD_C: begin
                r_e1     <= r_rd;
                r_sel    <= 1'b0;
                r_sq_cnt <= 2'd0;
                r_acc    <= '0;
            end
            S_SQ: begin
                r_acc    <= r_acc + SQ_W'($unsigned(sq));
                r_sq_cnt <= r_sq_cnt + 2'd1;
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    r_sq_cnt <= 2'd0;
                    r_acc    <= '0;
                    r_sel    <= 1'b1;
                    if (r_sel) begin
                        r_m2 <= sqrt_root;
                    end else begin
                        r_m1  <= sqrt_root;
                        r_mag <= sqrt_root;
                    end
                end
            end
            S_WEIGHT: begin
                if (span == 32'd0 || elapsed[31]) begin
                    r_w <= 17'd0;
                end else begin
                    r_w <= WEIGHT_ONE;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    r_w <= {1'b0, div_quot[15:0]};
                end
            end
            S_MUL:    r_prod <= r_w * diff;
            S_INTERP: begin
                if (r_m2 >= r_m1) begin
                    r_mag <= r_m1 + r_prod[39:16];
                end else begin
                    r_mag <= r_m1 - r_prod[39:16];
                end
            end
            S_NORM:   r_neg <= dnorm[25];
            S_NORMW: begin
                if (div_done) begin
                    r_result.magnitude <= r_mag;
                    if (r_neg) begin
                        r_result.normalized <= (div_quot > NORM_NEG_LIM) ? NORM_MIN
                                               : 24'(-div_quot);
                    end else begin
                        r_result.normalized <= (div_quot > NORM_POS_LIM) ? NORM_MAX
                                               : $signed(div_quot[23:0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    amti_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (sqrt_go),
        .i_radicand ({r_acc, 16'h0000}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    amti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

[src/accel_magnitude_time_interpolator_unit.sv]
// Top level of the accelerometer magnitude interpolator.
// Depends on amti_pkg, amti_front, amti_back.
//
// Command channel: a beat is taken at a clock edge with start high and busy
// low. op selects begin batch, slot, or query; the no-op code is dropped.
// A two-entry queue in the front end feeds the back end, so busy
// rises only when both entries are held.
// Result channel: o_valid strobes for one cycle with o_result, once per query.
// The receiver cannot stall; results are never held back.
// A query on a table of two or more entries has its result time set by the walk
// steps, the shared square root (two magnitudes), the weight divide (skipped
// when the weight is 0 or 1) and the normalization divide.
// One item is worked at a time.
// Configuration: i_cfg_we writes rest level from i_cfg_wdata.
// Reset (synchronous, active low): empty table, walk pointer 0, end slot
// (0, 0, 1000) at time 0, rest level 1000, queue empty.
module accel_magnitude_time_interpolator_unit #(
    parameter int MAX_POINTS = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  amti_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output amti_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import amti_pkg::*;

    logic [15:0] r_rest;
    logic        q_valid;
    logic        q_ready;
    t_in_item    q_item;

    // hold the rest level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RESET;
        end else if (i_cfg_we) begin
            r_rest <= i_cfg_wdata;
        end
    end

    amti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    amti_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_ready  (q_ready),
        .i_rest   (r_rest),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // a query result is never followed by another in the next cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    // a full queue always presents an item to the back end
    a_full_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> q_valid)
        else $error("queue full but nothing presented");

    // a result strobe comes only out of the back end's final divide wait, in which it takes no item
    a_no_take_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(!q_ready))
        else $error("back end idle in the cycle before a result");

endmodule

[tb/sv/accel_magnitude_time_interpolator_unit_test.sv]
// Testbench for the accelerometer magnitude interpolator: random and directed commands,
// a bit-exact predictor of the batch table, walk, root, interpolation and normalization, result checking.
// Depends on amti_pkg and accel_magnitude_time_interpolator_unit.
`timescale 1ns / 1ps

module accel_magnitude_time_interpolator_unit_test;
    import amti_pkg::*;

    localparam int NPTS = 18;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_item    i_item;
    logic        busy;
    logic        o_valid;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    accel_magnitude_time_interpolator_unit #(.MAX_POINTS(NPTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    t_accel      tab_acc [NPTS];
    logic [31:0] tab_t [NPTS];
    int unsigned n_pts, walk;
    t_accel      end_acc;
    logic [31:0] end_t;
    bit          first_b, open_b;
    logic [15:0] rest_mg;

    t_in_item  cmd_q[$];
    t_out_item mag_expect_q[$];
    int        errors;
    longint    cycles;
    int        burst_left, gap_left;
    bit        hold_off;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] root64(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] mag_of(t_accel a);
        logic [63:0] s;
        s = 64'(longint'(a.x) * a.x) + 64'(longint'(a.y) * a.y) + 64'(longint'(a.z) * a.z);
        return root64(s << 16);
    endfunction

    // apply one accepted beat to the predictor
    task automatic predict_beat(t_in_item it);
        t_accel a;
        logic [31:0] m1, m2, span, el, w, mag, rest;
        longint num, norm;
        t_out_item r;
        case (it.op)
            OP_BEGIN: begin
                walk = 0;
                tab_acc[0] = end_acc;
                tab_t[0] = end_t;
                n_pts = 1;
                open_b = it.received;
            end
            OP_SLOT: begin
                if (open_b) begin
                    a.x = it.accel_x; a.y = it.accel_y; a.z = it.accel_z;
                    if (first_b) begin
                        tab_acc[0] = a;
                        tab_t[0] = it.sample_time;
                        first_b = 0;
                    end
                    if (n_pts < NPTS) begin
                        tab_acc[n_pts] = a;
                        tab_t[n_pts] = it.sample_time;
                        n_pts++;
                    end
                    end_acc = a;
                    end_t = it.sample_time;
                end
            end
            OP_QUERY: begin
                mag = 0;
                rest = (rest_mg != 0) ? {16'd0, rest_mg} : 32'd1;
                if (n_pts == 1) begin
                    mag = mag_of(tab_acc[0]);
                end else if (n_pts >= 2) begin
                    while (walk < n_pts - 2 && tab_t[walk + 1] < it.query_time) walk++;
                    m1 = mag_of(tab_acc[walk]);
                    m2 = mag_of(tab_acc[walk + 1]);
                    span = tab_t[walk + 1] - tab_t[walk];
                    el = it.query_time - tab_t[walk];
                    w = 0;
                    if (span != 0) begin
                        if (el[31]) w = 0;
                        else if (el >= span) w = 32'h10000;
                        else w = 32'(({32'd0, el} << 16) / span);
                    end
                    if (m2 >= m1) mag = m1 + 32'((64'(w) * (m2 - m1)) >> 16);
                    else mag = m1 - 32'((64'(w) * (m1 - m2)) >> 16);
                end
                num = (longint'(mag) - longint'(rest) * 256) * 256;
                norm = num / longint'(rest);
                if (norm > 8388607) norm = 8388607;
                if (norm < -8388608) norm = -8388608;
                r.magnitude = mag[23:0];
                r.normalized = norm[23:0];
                mag_expect_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver: bursts and gaps, at most one nonblocking write of start per edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_beat(i_item);
                void'(cmd_q.pop_front());
            end
            if (start && busy) begin
                // hold the beat
            end else if (hold_off || cmd_q.size() == 0 ||
                         (start && !busy ? cmd_q.size() == 0 : 0)) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_item <= cmd_q[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
                    gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 60);
                end
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        cycles++;
        if (i_rst_n && o_valid) begin
            if (mag_expect_q.size() == 0) begin
                $display("%0t: unexpected result mag=%h norm=%h", $time,
                         o_result.magnitude, o_result.normalized);
                errors++;
            end else begin
                e = mag_expect_q.pop_front();
                if (e.magnitude !== o_result.magnitude) begin
                    $display("%0t: magnitude expected %h actual %h", $time,
                             e.magnitude, o_result.magnitude);
                    errors++;
                end
                if (e.normalized !== o_result.normalized) begin
                    $display("%0t: normalized expected %h actual %h", $time,
                             e.normalized, o_result.normalized);
                    errors++;
                end
            end
        end
        if (cycles > 4000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_item mk(logic [1:0] op, bit rcv, int x, int y, int z,
                                    logic [31:0] st, logic [31:0] qt);
        t_in_item it;
        it.op = op; it.received = rcv;
        it.accel_x = 16'(x); it.accel_y = 16'(y); it.accel_z = 16'(z);
        it.sample_time = st; it.query_time = qt;
        return it;
    endfunction

    function automatic t_in_item rnd_noise();
        t_in_item it;
        it = mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                $urandom, $urandom, $urandom);
        return it;
    endfunction

    function automatic int rnd_acc();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 4000)) - 2000;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // wait until idle, then write the rest register
    task automatic write_rest(logic [15:0] v);
        wait (cmd_q.size() == 0 && !start);
        wait (mag_expect_q.size() == 0);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rest_mg = v;
    endtask

    // one batch, mostly well-formed, followed by queries mostly across its time range
    task automatic add_batch(int nslots, int nq);
        logic [31:0] t, t0;
        t0 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
        t = t0;
        cmd_q.push_back(mk(OP_BEGIN, nslots != 0 || $urandom_range(0, 1), 0, 0, 0, 0, 0));
        for (int i = 0; i < nslots; i++) begin
            t = t + ($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2000));
            cmd_q.push_back(mk(OP_SLOT, 0, rnd_acc(), rnd_acc(), rnd_acc(),
                               $urandom_range(0, 15) == 0 ? $urandom : t, $urandom));
        end
        for (int i = 0; i < nq; i++)
            cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0,
                $urandom_range(0, 7) == 0 ? $urandom :
                t0 + $urandom_range(0, (t - t0) + 1000) - 500));
    endtask

    initial begin
        int sent;
        i_rst_n = 1'b0; start = 1'b0; i_item = '0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        errors = 0; cycles = 0; burst_left = 0; gap_left = 0; hold_off = 0;
        n_pts = 0; walk = 0; end_acc = '{x: 0, y: 0, z: 16'sd1000}; end_t = 0;
        first_b = 1; open_b = 0; rest_mg = REST_RESET;
        for (int i = 0; i < NPTS; i++) begin
            tab_acc[i] = '0; tab_t[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ignored slot, no-op, first slot, one entry, extremes
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        cmd_q.push_back(mk(OP_SLOT, 0, 5, 5, 5, 7, 0));
        cmd_q.push_back(mk(OP_NONE, 1, -1, -1, -1, 32'hFFFFFFFF, 32'hFFFFFFFF));
        cmd_q.push_back(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_BEGIN, 1, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_SLOT, 0, -32768, -32768, -32768, 100, 0));
        cmd_q.push_back(mk(OP_SLOT, 0, 32767, 32767, 32767, 100, 0));
        cmd_q.push_back(mk(OP_SLOT, 0, 0, 0, 0, 32'hFFFFFFFF, 0));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 50));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 100));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'h80000000));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        cmd_q.push_back(mk(OP_BEGIN, 1, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 3));
        add_batch(NPTS + 3, 4);
        write_rest(16'd1);
        add_batch(2, 3);
        write_rest(16'd0);
        add_batch(1, 2);
        write_rest(16'hFFFF);
        add_batch(3, 3);

        // hold off the sender until all results have arrived
        wait (cmd_q.size() == 0);
        hold_off = 1;
        wait (!start && mag_expect_q.size() == 0);
        hold_off = 0;

        // random: batches with random content plus noise, rest changed by phase
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_rest(ph == 0 ? 16'd1000 : ph == 5 ? 16'd1 : 16'($urandom_range(1, 65535)));
            while (sent < (ph + 1) * 280) begin
                if ($urandom_range(0, 9) < 8) begin
                    int ns, nq;
                    ns = $urandom_range(0, 12) == 0 ? $urandom_range(NPTS, NPTS + 4)
                                                    : $urandom_range(0, 6);
                    nq = $urandom_range(1, 5);
                    add_batch(ns, nq);
                    sent += ns + nq + 1;
                end else begin
                    cmd_q.push_back(rnd_noise());
                    sent++;
                end
            end
        end

        wait (cmd_q.size() == 0 && !start);
        wait (mag_expect_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && mag_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
src/amti_pkg.sv
src/amti_front.sv
src/amti_isqrt.sv
src/amti_div.sv
src/amti_back.sv
src/accel_magnitude_time_interpolator_unit.sv
tb/sv/accel_magnitude_time_interpolator_unit_test.sv
